/* hdl/rasm_pkg.sv */
// Package for the resistive array scan/measure core.
// Types, constants and the drive pattern table shared by the lane, the top level and the testbench.
// Depends on nothing.
package rasm_pkg;

   localparam int ADC_BITS_DEF  = 12;
   localparam int FRAC_BITS_DEF = 4;
   localparam int SAMPLE_W      = 12;
   localparam int REF_W         = 14;
   localparam int CNT_W         = 10;
   localparam int RES_W         = 32;
   localparam int NUM_COLS      = 3;
   localparam int LAST_PHASE    = 6;

   localparam logic [REF_W-1:0] REF1_RESET = 14'd1016;
   localparam logic [REF_W-1:0] REF2_RESET = 14'd1005;
   localparam logic [REF_W-1:0] REF3_RESET = 14'd1002;
   localparam logic [CNT_W-1:0] SPP_RESET  = 10'd200;

   typedef enum logic [1:0] {
      CSR_REF_COL1 = 2'd0,
      CSR_REF_COL2 = 2'd1,
      CSR_REF_COL3 = 2'd2,
      CSR_SPP      = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_PATTERN = 1'b0,
      KIND_VALUE   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_AVG,
      L_MUL,
      L_RSTART,
      L_RDIV
   } lane_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_AVG,
      T_PAT,
      T_RSTART,
      T_RWAIT,
      T_EMIT
   } top_state_type;

   typedef struct packed {
      logic             add;
      logic             close;
      logic             start_ratio;
      logic             method;
      logic [1:0]       row;
      logic [2:0]       phase;
      logic [CNT_W-1:0] spp;
   } lane_ctrl_type;

   typedef struct packed {
      logic                    done;
      logic signed [RES_W-1:0] value;
      logic                    err;
   } lane_stat_type;

   // row-line levels for each phase, bit0 is row one, 0 is driven low
   function automatic logic [3:0] drive_of(input logic [2:0] phase);
      logic [3:0] pat;
      case (phase)
         3'd0:    pat = 4'd14;
         3'd1:    pat = 4'd13;
         3'd2:    pat = 4'd11;
         3'd3:    pat = 4'd7;
         3'd4:    pat = 4'd6;
         3'd5:    pat = 4'd5;
         3'd6:    pat = 4'd3;
         default: pat = 4'd14;
      endcase
      return pat;
   endfunction

endpackage

/* hdl/rasm_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by rasm_lane.
module rasm_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 22
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff, done_ff;
   logic [DEN_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* hdl/rasm_lane.sv */
// One column lane: sample accumulation, pattern averages and the two ratio methods.
// Depends on rasm_pkg and rasm_div.
module rasm_lane #(
   parameter int ADC_BITS      = rasm_pkg::ADC_BITS_DEF,
   parameter int FRACTION_BITS = rasm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rasm_pkg::lane_ctrl_type       ctrl,
   input  logic [rasm_pkg::SAMPLE_W-1:0] sample,
   input  logic [rasm_pkg::REF_W-1:0]    ref_res,
   output rasm_pkg::lane_stat_type       stat
);
   import rasm_pkg::*;

   localparam int SUM_W    = ADC_BITS + CNT_W;
   localparam int NUM_W    = SUM_W + REF_W + FRACTION_BITS;
   localparam int QW       = NUM_W > 33 ? NUM_W : 33;
   localparam int ADC_MASK = (1 << ADC_BITS) - 1;
   localparam int FS       = (1 << ADC_BITS) - 1;

   lane_state_type state_ff, state_in;

   logic [SUM_W-1:0] sum_ff, sum_next;
   logic [SUM_W-1:0] a_ff [3];
   logic [SUM_W-1:0] b_ff [3];
   logic [SUM_W-1:0] a3_ff;
   logic [SUM_W-1:0] mag_num_ff, mag_den_ff;
   logic             neg_ff, dz_ff;
   logic [SUM_W+REF_W-1:0] prod_ff;
   logic signed [RES_W-1:0] val_ff, val_in;
   logic             err_ff, done_ff;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_q;
   logic [SUM_W-1:0] div_den;

   logic signed [SUM_W:0] a_row, a_all, b_row, fs_s, num_s, den_s;
   logic [QW-1:0]         q_ext;
   logic [SAMPLE_W-1:0]   masked;

   always_comb begin
      masked   = sample & SAMPLE_W'(ADC_MASK);
      sum_next = sum_ff + SUM_W'(masked);
      a_row = $signed({1'b0, a_ff[ctrl.row]});
      b_row = $signed({1'b0, b_ff[ctrl.row]});
      a_all = $signed({1'b0, a3_ff});
      fs_s  = $signed((SUM_W+1)'(FS));
      if (ctrl.method) begin
         num_s = a_row - b_row;
         den_s = a_all - b_row;
      end else begin
         num_s = fs_s - a_all;
         den_s = fs_s - a_row;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = NUM_W'(sum_next);
      div_den   = SUM_W'((ctrl.spp == '0) ? CNT_W'(1) : ctrl.spp);
      case (state_ff)
         L_IDLE: begin
            if (ctrl.close) begin
               div_start = 1'b1;
               state_in  = L_AVG;
            end else if (ctrl.start_ratio) begin
               state_in = L_MUL;
            end
         end
         L_AVG:    if (div_done) state_in = L_IDLE;
         L_MUL:    state_in = L_RSTART;
         L_RSTART: begin
            div_start = 1'b1;
            div_num   = NUM_W'(prod_ff) << FRACTION_BITS;
            div_den   = mag_den_ff;
            state_in  = L_RDIV;
         end
         L_RDIV:   if (div_done) state_in = L_IDLE;
         default:  state_in = L_IDLE;
      endcase
   end

   // saturate and apply the sign of the ratio; a zero divisor gives zero
   always_comb begin
      q_ext = QW'(div_q);
      if (dz_ff) begin
         val_in = '0;
      end else if (neg_ff) begin
         val_in = (q_ext > QW'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                               : -$signed(RES_W'(q_ext));
      end else begin
         val_in = (q_ext > QW'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                : $signed(RES_W'(q_ext));
      end
   end

   rasm_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         sum_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= div_done && (state_ff == L_AVG || state_ff == L_RDIV);
         if (ctrl.close)    sum_ff <= '0;
         else if (ctrl.add) sum_ff <= sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == L_AVG && div_done) begin
         if (ctrl.phase < 3'd3)       a_ff[ctrl.phase[1:0]] <= SUM_W'(div_q);
         else if (ctrl.phase == 3'd3) a3_ff <= SUM_W'(div_q);
         else                         b_ff[2'(ctrl.phase - 3'd4)] <= SUM_W'(div_q);
      end
      if (state_ff == L_IDLE && ctrl.start_ratio) begin
         mag_num_ff <= SUM_W'(num_s[SUM_W] ? -num_s : num_s);
         mag_den_ff <= SUM_W'(den_s[SUM_W] ? -den_s : den_s);
         neg_ff     <= num_s[SUM_W] ^ den_s[SUM_W];
         dz_ff      <= den_s == '0;
      end
      if (state_ff == L_MUL) prod_ff <= mag_num_ff * ref_res;
      if (state_ff == L_RDIV && div_done) begin
         val_ff <= val_in;
         err_ff <= dz_ff;
      end
   end

   assign stat = '{done: done_ff, value: val_ff, err: err_ff};
endmodule

/* hdl/resistive_array_scan_measure_core.sv */
// Top level: three column lanes, scan sequencer, result merge and output register.
// Depends on rasm_pkg, rasm_lane and rasm_div.
//
//   channel | ports           | role
//   --------+-----------------+-----------------------------------------
//   req     | valid/ready     | one sample per column per request
//   rsp     | valid/ready     | pattern change or resistance value
//   csr     | we/index/wdata  | reference resistors, samples per pattern
//
// A request that closes a pattern starts the per-lane average division; further requests
// wait until it ends and the pattern change is emitted. The seventh pattern adds six
// ratio steps, every step emitting three values, before its pattern change.
// Reset is synchronous and clears control state; requests wait while results stall.
module resistive_array_scan_measure_core #(
   parameter int ADC_BITS      = rasm_pkg::ADC_BITS_DEF,
   parameter int FRACTION_BITS = rasm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rasm_pkg::SAMPLE_W-1:0] req_sample_col1,
   input  logic [rasm_pkg::SAMPLE_W-1:0] req_sample_col2,
   input  logic [rasm_pkg::SAMPLE_W-1:0] req_sample_col3,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [3:0]                    rsp_drive_pattern,
   output logic [1:0]                    rsp_row,
   output logic [1:0]                    rsp_column,
   output logic                          rsp_method,
   output logic signed [rasm_pkg::RES_W-1:0] rsp_resistance,
   output logic                          rsp_div_error,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [rasm_pkg::REF_W-1:0]    csr_wdata
);
   import rasm_pkg::*;

   top_state_type state_ff, state_in;

   logic [REF_W-1:0] ref_ff [NUM_COLS];
   logic [CNT_W-1:0] spp_ff, count_ff, count_next, spp_eff;
   logic [2:0]       phase_ff;
   logic             method_ff;
   logic [1:0]       row_ff, col_ff;

   logic             accept, complete, slot_free, lanes_done;
   logic             load_pat, load_val, start_ratio;
   lane_ctrl_type    ctrl;
   lane_stat_type    stat [NUM_COLS];
   logic [SAMPLE_W-1:0] samples [NUM_COLS];

   logic             rsp_valid_ff, rsp_kind_ff, rsp_method_ff, rsp_err_ff, rsp_last_ff;
   logic [3:0]       rsp_pat_ff;
   logic [1:0]       rsp_row_ff, rsp_col_ff;
   logic signed [RES_W-1:0] rsp_res_ff;
   lane_stat_type    sel;

   assign samples[0] = req_sample_col1;
   assign samples[1] = req_sample_col2;
   assign samples[2] = req_sample_col3;

   always_comb begin
      req_ready  = state_ff == T_IDLE;
      accept     = req_valid && req_ready;
      spp_eff    = (spp_ff == '0) ? CNT_W'(1) : spp_ff;
      count_next = count_ff + 1'b1;
      complete   = count_next >= spp_eff;
      slot_free  = !rsp_valid_ff || rsp_ready;
      lanes_done = stat[0].done && stat[1].done && stat[2].done;
      sel        = stat[col_ff];
   end

   always_comb begin
      state_in    = state_ff;
      load_pat    = 1'b0;
      load_val    = 1'b0;
      start_ratio = 1'b0;
      case (state_ff)
         T_IDLE:   if (accept && complete) state_in = T_AVG;
         T_AVG: begin
            if (lanes_done) state_in = (phase_ff == 3'(LAST_PHASE)) ? T_RSTART : T_PAT;
         end
         T_PAT: begin
            if (slot_free) begin
               load_pat = 1'b1;
               state_in = T_IDLE;
            end
         end
         T_RSTART: begin
            start_ratio = 1'b1;
            state_in    = T_RWAIT;
         end
         T_RWAIT:  if (lanes_done) state_in = T_EMIT;
         T_EMIT: begin
            if (slot_free) begin
               load_val = 1'b1;
               if (col_ff == 2'd2)
                  state_in = (method_ff && row_ff == 2'd0) ? T_PAT : T_RSTART;
            end
         end
         default:  state_in = T_IDLE;
      endcase
   end

   always_comb begin
      ctrl.add         = accept;
      ctrl.close       = accept && complete;
      ctrl.start_ratio = start_ratio;
      ctrl.method      = method_ff;
      ctrl.row         = row_ff;
      ctrl.phase       = phase_ff;
      ctrl.spp         = spp_ff;
   end

   for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
      rasm_lane #(.ADC_BITS(ADC_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sample  (samples[c]),
         .ref_res (ref_ff[c]),
         .stat    (stat[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         ref_ff[0]    <= REF1_RESET;
         ref_ff[1]    <= REF2_RESET;
         ref_ff[2]    <= REF3_RESET;
         spp_ff       <= SPP_RESET;
         count_ff     <= '0;
         phase_ff     <= '0;
         method_ff    <= 1'b0;
         row_ff       <= 2'd2;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_REF_COL1: ref_ff[0] <= csr_wdata;
               CSR_REF_COL2: ref_ff[1] <= csr_wdata;
               CSR_REF_COL3: ref_ff[2] <= csr_wdata;
               CSR_SPP:      spp_ff    <= csr_wdata[CNT_W-1:0];
               default:      ;
            endcase
         end
         if (accept) count_ff <= complete ? '0 : count_next;
         if (state_ff == T_AVG && lanes_done && phase_ff != 3'(LAST_PHASE))
            phase_ff <= phase_ff + 1'b1;
         if (load_val) begin
            col_ff <= (col_ff == 2'd2) ? 2'd0 : col_ff + 1'b1;
            if (col_ff == 2'd2) begin
               if (row_ff == 2'd0) begin
                  method_ff <= !method_ff;
                  row_ff    <= 2'd2;
                  if (method_ff) phase_ff <= '0;
               end else begin
                  row_ff <= row_ff - 1'b1;
               end
            end
         end
         if (load_pat || load_val) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)       rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_pat) begin
         rsp_kind_ff   <= KIND_PATTERN;
         rsp_pat_ff    <= drive_of(phase_ff);
         rsp_row_ff    <= '0;
         rsp_col_ff    <= '0;
         rsp_method_ff <= 1'b0;
         rsp_res_ff    <= '0;
         rsp_err_ff    <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end else if (load_val) begin
         rsp_kind_ff   <= KIND_VALUE;
         rsp_pat_ff    <= '0;
         rsp_row_ff    <= row_ff + 1'b1;
         rsp_col_ff    <= col_ff + 1'b1;
         rsp_method_ff <= method_ff;
         rsp_res_ff    <= sel.value;
         rsp_err_ff    <= sel.err;
         rsp_last_ff   <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_drive_pattern = rsp_pat_ff;
   assign rsp_row           = rsp_row_ff;
   assign rsp_column        = rsp_col_ff;
   assign rsp_method        = rsp_method_ff;
   assign rsp_resistance    = rsp_res_ff;
   assign rsp_div_error     = rsp_err_ff;
   assign rsp_last          = rsp_last_ff;
endmodule

/* tb/resistive_array_scan_measure_core_tb.sv */
// Testbench for resistive_array_scan_measure_core: table-driven directed scans, then random
// scans under varied handshake idling, all results checked against an in-bench scan model.
// Depends on rasm_pkg and the core RTL.
module resistive_array_scan_measure_core_tb;
   import rasm_pkg::*;

   typedef struct {
      logic        kind;
      logic [3:0]  pat;
      logic [1:0]  row;
      logic [1:0]  col;
      logic        method;
      logic signed [31:0] res;
      logic        err;
      logic        last;
   } meas_type;

   typedef struct {
      logic [11:0] s1, s2, s3;
      logic        has_exp;   // expected pattern typed in
      logic [3:0]  exp_pat;
   } stim_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [11:0] req_sample_col1 = 0, req_sample_col2 = 0, req_sample_col3 = 0;
   logic req_ready, rsp_valid, rsp_kind, rsp_method, rsp_div_error, rsp_last;
   logic [3:0] rsp_drive_pattern;
   logic [1:0] rsp_row, rsp_column;
   logic signed [31:0] rsp_resistance;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [13:0] csr_wdata = 0;

   resistive_array_scan_measure_core dut (.*);

   always #2 clock = ~clock;

   // scan model state
   logic [13:0] m_ref [3];
   logic [9:0]  m_spp;
   int unsigned m_phase, m_count;
   longint unsigned m_sums [3];
   longint      m_avg [21];

   meas_type expected_q [$];
   int mismatches = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_rsp = 0;
   int quiet_cycles = 0;
   bit started = 0;

   function automatic longint ratio(longint num, longint den, logic [13:0] rr,
                                    output logic err);
      longint unsigned an, ad, q;
      bit neg;
      if (den == 0) begin
         err = 1;
         return 0;
      end
      err = 0;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q = (an * rr * 16) / ad;
      if (neg) begin
         if (q > 64'd2147483648) q = 64'd2147483648;
         return -longint'(q);
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return q;
   endfunction

   function automatic meas_type blank();
      meas_type m;
      m = '{kind: KIND_PATTERN, pat: 0, row: 0, col: 0, method: 0, res: 0, err: 0, last: 0};
      return m;
   endfunction

   // update the scan model with one sample set, queueing what it causes
   task automatic predict_scan(input logic [11:0] s1, input logic [11:0] s2,
                               input logic [11:0] s3);
      int unsigned spp, p;
      longint num, den;
      meas_type m;
      spp = m_spp == 0 ? 1 : m_spp;
      m_sums[0] += s1; m_sums[1] += s2; m_sums[2] += s3;
      m_count++;
      if (m_count >= spp) begin
         p = m_phase > 6 ? 6 : m_phase;
         for (int c = 0; c < 3; c++) begin
            m_avg[p*3+c] = m_sums[c] / spp;
            m_sums[c] = 0;
         end
         m_count = 0;
         if (p >= 6) begin
            for (int md = 0; md < 2; md++)
               for (int r = 2; r >= 0; r--)
                  for (int c = 0; c < 3; c++) begin
                     if (md == 0) begin
                        num = 4095 - m_avg[9+c];
                        den = 4095 - m_avg[r*3+c];
                     end else begin
                        num = m_avg[r*3+c] - m_avg[12+r*3+c];
                        den = m_avg[9+c] - m_avg[12+r*3+c];
                     end
                     m = blank();
                     m.kind = KIND_VALUE;
                     m.row = r + 1;
                     m.col = c + 1;
                     m.method = md;
                     m.res = 32'(ratio(num, den, m_ref[c], m.err));
                     expected_q.push_back(m);
                  end
            m_phase = 0;
         end else
            m_phase = p + 1;
         m = blank();
         m.pat = drive_of(3'(m_phase));
         m.last = 1;
         expected_q.push_back(m);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [13:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_SPP) m_spp = val[9:0];
      else m_ref[idx] = val;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   // valid stays up between back-to-back requests unless send idling drops it; wait_drained drops it
   task automatic send(input logic [11:0] s1, input logic [11:0] s2, input logic [11:0] s3);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1;
      req_sample_col1 <= s1;
      req_sample_col2 <= s2;
      req_sample_col3 <= s3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_scan(s1, s2, s3);
      @(negedge clock);
   endtask

   // one full scan of seven patterns with per-pattern base levels and noise
   task automatic random_scan(input int noise);
      logic [11:0] base [3];
      int spp;
      spp = m_spp == 0 ? 1 : m_spp;
      for (int p = 0; p < 7; p++) begin
         for (int c = 0; c < 3; c++) base[c] = $urandom_range(4095);
         if ($urandom_range(9) == 0) base[0] = 4095;
         for (int i = 0; i < spp; i++)
            send(12'(base[0] + $urandom_range(noise)), 12'(base[1] + $urandom_range(noise)),
                 12'(base[2] + $urandom_range(noise)));
      end
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_rsp) rsp_ready <= 0;
      else rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         meas_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result kind=%0d res=%0d", rsp_kind,
                                           rsp_resistance);
         end else begin
            e = expected_q.pop_front();
            if (e.kind !== rsp_kind || e.pat !== rsp_drive_pattern || e.row !== rsp_row ||
                e.col !== rsp_column || e.method !== rsp_method || e.res !== rsp_resistance ||
                e.err !== rsp_div_error || e.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp k%0d p%0d r%0d c%0d m%0d v%0d e%0d l%0d",
                     e.kind, e.pat, e.row, e.col, e.method, e.res, e.err, e.last,
                     ", got k%0d p%0d r%0d c%0d m%0d v%0d e%0d l%0d",
                     rsp_kind, rsp_drive_pattern, rsp_row, rsp_column, rsp_method,
                     rsp_resistance, rsp_div_error, rsp_last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !started) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("resistive_array_scan_measure_core_tb: FAIL");
         $finish;
      end
   end

   stim_row_type dir_tab [$];

   initial begin
      m_ref[0] = REF1_RESET; m_ref[1] = REF2_RESET; m_ref[2] = REF3_RESET;
      m_spp = SPP_RESET;
      m_phase = 0; m_count = 0;
      for (int c = 0; c < 3; c++) m_sums[c] = 0;
      for (int i = 0; i < 21; i++) m_avg[i] = 0;
      repeat (9) @(negedge clock);
      reset <= 0;
      started = 1;
      @(negedge clock);

      // directed: one sample per pattern, extremes, zero divisors, saturation
      write_reg(CSR_SPP, 1);
      write_reg(CSR_REF_COL1, 14'h3FFF);
      write_reg(CSR_REF_COL2, 0);
      write_reg(CSR_REF_COL3, 1);
      dir_tab = '{
         '{12'd0,    12'd0,    12'd4095, 1, 4'd13},
         '{12'd4094, 12'd4095, 12'd0,    1, 4'd11},
         '{12'd4095, 12'd100,  12'd4095, 1, 4'd7},
         '{12'd4094, 12'd4095, 12'd0,    1, 4'd6},
         '{12'd0,    12'd4095, 12'd4095, 1, 4'd5},
         '{12'd4095, 12'd0,    12'd1,    1, 4'd3},
         '{12'd2048, 12'd4095, 12'd2047, 0, 4'd0},
         '{12'hAAA,  12'h555,  12'hFFF,  1, 4'd13},
         '{12'h555,  12'hAAA,  12'h000,  1, 4'd11},
         '{12'd10,   12'd20,   12'd30,   1, 4'd7},
         '{12'd3000, 12'd10,   12'd5,    1, 4'd6},
         '{12'd1,    12'd2,    12'd3,    1, 4'd5},
         '{12'd7,    12'd8,    12'd9,    1, 4'd3},
         '{12'd4095, 12'd4095, 12'd4095, 0, 4'd0}};
      foreach (dir_tab[i]) begin
         send(dir_tab[i].s1, dir_tab[i].s2, dir_tab[i].s3);
         if (dir_tab[i].has_exp && expected_q[$].pat !== dir_tab[i].exp_pat) begin
            mismatches++;
            $display("table row %0d: pattern %0d, table says %0d", i, expected_q[$].pat,
                     dir_tab[i].exp_pat);
         end
      end
      wait_drained();
      // zero samples per pattern acts as one
      write_reg(CSR_SPP, 0);
      for (int i = 0; i < 7; i++) send(12'(i * 600), 12'(4095 - i), 12'(i));
      wait_drained();
      // lower the count mid-pattern
      write_reg(CSR_SPP, 5);
      send(100, 200, 300); send(101, 201, 301); send(102, 202, 302);
      wait_drained();
      write_reg(CSR_SPP, 2);
      send(4000, 4000, 4000);
      wait_drained();

      // random scans in three idling regimes
      write_reg(CSR_REF_COL1, REF1_RESET);
      write_reg(CSR_REF_COL2, REF2_RESET);
      write_reg(CSR_REF_COL3, REF3_RESET);
      write_reg(CSR_SPP, 3);
      for (int regime = 0; regime < 3; regime++) begin
         send_idle = regime == 0 ? 11 : regime == 1 ? 68 : 0;
         recv_idle = regime == 0 ? 68 : regime == 1 ? 11 : 0;
         for (int s = 0; s < 10; s++) begin
            if (s == 4 && regime == 2) begin
               fork
                  begin
                     hold_rsp = 1;
                     repeat (600) @(negedge clock);
                     hold_rsp = 0;
                  end
               join_none
            end
            random_scan(s % 2 ? 4095 : 7);
         end
         wait_drained();
         write_reg(CSR_REF_COL1, 14'($urandom_range(16383)));
         write_reg(CSR_REF_COL2, 14'($urandom_range(16383)));
         write_reg(CSR_REF_COL3, regime == 1 ? 14'h3FFF : 14'($urandom_range(16383)));
         write_reg(CSR_SPP, 10'($urandom_range(1, 3)));
      end
      // one sample at the largest count, leaving a partial pattern
      write_reg(CSR_SPP, 10'd1023);
      send(4095, 4095, 4095);
      wait_drained();

      if (mismatches == 0 && expected_q.size() == 0)
         $display("resistive_array_scan_measure_core_tb: PASS");
      else
         $display("resistive_array_scan_measure_core_tb: FAIL");
      $finish;
   end
endmodule

/* resistive_array_scan_measure_core.f */
hdl/rasm_pkg.sv
hdl/rasm_div.sv
hdl/rasm_lane.sv
hdl/resistive_array_scan_measure_core.sv
tb/resistive_array_scan_measure_core_tb.sv
